// ----- hdl/slsort_pkg.sv -----
// Package of shared constants and control/status types for the stable layer sort.
package slsort_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 16;
	localparam int KEY_W    = 16;
	localparam int TAG_W    = 32;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic last_one;
	} stat_t;

endpackage

// ----- hdl/slsort_ctrl.sv -----
// Controller state machine: fill phase takes beats, drain phase emits the sorted batch.
module slsort_ctrl
	import slsort_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  batch_last,
	input  logic  out_stall,
	input  stat_t stat,
	output logic  in_stall,
	output logic  out_valid,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (in_valid && batch_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!out_stall && stat.last_one) begin
					state_nxt = ST_FILL;
				end
			end
			default: state_nxt = ST_FILL;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_FILL: begin
				in_stall = 1'b0;
				cmd.ins  = in_valid && !stat.full;
			end
			ST_DRAIN: begin
				out_valid = 1'b1;
				cmd.shift = !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ----- hdl/slsort_dp.sv -----
// Datapath: a row of sort cells with parallel insertion and a shift-out drain.
module slsort_dp
	import slsort_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [TAG_W-1:0]        new_tag,
	output stat_t                   stat,
	output logic [KEY_BITS-1:0]     head_key,
	output logic [TAG_W-1:0]        head_tag
);

	localparam logic [KEY_BITS-1:0] SIGN_FLIP = {1'b1, {(KEY_BITS-1){1'b0}}};

	logic [KEY_BITS-1:0] key_q [CAPACITY];
	logic [TAG_W-1:0]    tag_q [CAPACITY];
	logic [COUNT_W-1:0]  count_q;
	logic [CAPACITY-1:0] gt;
	logic [CAPACITY-1:0] gt_prev;
	logic [KEY_BITS-1:0] new_ord;

	assign new_ord = new_key ^ SIGN_FLIP;
	assign gt_prev = {gt[CAPACITY-2:0], 1'b0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                occ;
		logic [KEY_BITS-1:0] up_key;
		logic [TAG_W-1:0]    up_tag;

		assign occ   = COUNT_W'(i) < count_q;
		assign gt[i] = occ && ((key_q[i] ^ SIGN_FLIP) > new_ord);

		if (i < CAPACITY - 1) begin : g_up
			assign up_key = key_q[i+1];
			assign up_tag = tag_q[i+1];
		end else begin : g_end
			assign up_key = key_q[i];
			assign up_tag = tag_q[i];
		end

		always_ff @(posedge clk) begin
			if (cmd.ins) begin
				if (gt_prev[i]) begin
					key_q[i] <= key_q[(i == 0) ? 0 : i-1];
					tag_q[i] <= tag_q[(i == 0) ? 0 : i-1];
				end else if (gt[i] || (COUNT_W'(i) == count_q)) begin
					key_q[i] <= new_key;
					tag_q[i] <= new_tag;
				end
			end else if (cmd.shift) begin
				key_q[i] <= up_key;
				tag_q[i] <= up_tag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + COUNT_W'(1);
		end else if (cmd.shift) begin
			count_q <= count_q - COUNT_W'(1);
		end
	end

	assign stat.full     = count_q == COUNT_W'(CAPACITY);
	assign stat.last_one = count_q == COUNT_W'(1);
	assign head_key      = key_q[0];
	assign head_tag      = tag_q[0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_no_ins_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && cmd.shift))
		else $error("insert and shift in the same cycle");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> count_q != '0)
		else $error("shift from an empty store");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && count_q > COUNT_W'(1)) |->
		((key_q[0] ^ SIGN_FLIP) <= (key_q[1] ^ SIGN_FLIP)))
		else $error("store head out of order");

endmodule

// ----- hdl/stable_layer_sort_top.sv -----
// An entry is inserted in the cycle it is accepted if not full; one per cycle while filling.
// After the beat with batch_last, the first sorted beat is offered on the next cycle.
// A batch drains at one beat per cycle while out_stall is low; input is stalled meanwhile.
// The single insertion step across the row of 64 cells sets the fill rate.
// Reset (arst_n low) empties the store and returns to the fill phase; cell contents are kept.
// Top level of the stable layer sort: controller and datapath.
module stable_layer_sort_top
	import slsort_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [KEY_W-1:0]  layer_key,
	input  logic [TAG_W-1:0]         entry_tag,
	input  logic                     batch_last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [KEY_W-1:0]  sorted_key,
	output logic [TAG_W-1:0]         sorted_tag,
	output logic                     out_last
);

	cmd_t                         cmd;
	stat_t                        stat;
	logic [KEY_BITS+KEY_W-1:0]    in_ext;
	logic [KEY_BITS+KEY_W-1:0]    out_ext;
	logic [KEY_BITS-1:0]          head_key;

	assign in_ext  = {{KEY_BITS{1'b0}}, layer_key};
	assign out_ext = {{KEY_W{1'b0}}, head_key};

	slsort_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.batch_last (batch_last),
		.out_stall  (out_stall),
		.stat       (stat),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.cmd        (cmd)
	);

	slsort_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.new_key  (in_ext[KEY_BITS-1:0]),
		.new_tag  (entry_tag),
		.stat     (stat),
		.head_key (head_key),
		.head_tag (sorted_tag)
	);

	assign sorted_key = out_ext[KEY_W-1:0];
	assign out_last   = stat.last_one;

endmodule
